// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the ternary search block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define TS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ts assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define TS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ts assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define TS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ts assertion failed");

`endif

// ===== sv/ts_pkg.sv =====
// Package for the ternary search sorted table: widths, codes, state type
// and the divide-by-three helper. No dependencies.
package ts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = IDX_W + 1;
  localparam int BOUND_W     = IDX_W + 2;
  localparam int DIV3_SHIFT  = IDX_W + 1;
  localparam int DIV3_MUL    = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_ENTRIES_IN_USE = 1'b0,
    REG_UNUSED         = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_DONE
  } state_e;

  function automatic logic [IDX_W-1:0] div3(input logic [IDX_W-1:0] x);
    logic [IDX_W+DIV3_SHIFT-1:0] prod;
    prod = {{DIV3_SHIFT{1'b0}}, x} * (IDX_W + DIV3_SHIFT)'(DIV3_MUL);
    return prod[IDX_W+DIV3_SHIFT-1:DIV3_SHIFT];
  endfunction

endpackage

// ===== sv/ts_if.sv =====
// Valid/ready channel interfaces for search requests and responses.
// Depends on ts_pkg.
interface ts_req_if import ts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [IDX_W-1:0]          entry_index;
  logic signed [VALUE_W-1:0] entry_value;
  logic signed [VALUE_W-1:0] search_key;

  modport source (output valid, command, entry_index, entry_value, search_key,
                  input ready);
  modport sink (input valid, command, entry_index, entry_value, search_key,
                output ready);
endinterface

interface ts_rsp_if import ts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

// ===== sv/ternary_search_sorted_table.sv =====
// Ternary search over a sorted table of 1024 signed 32-bit entries.
// Write: one transaction per cycle while idle, no response. Search: each round
// has a probe and read state, then a compare state, up to 7 rounds; a hit or a
// miss then goes through the done state, which loads the response register.
// A search holds in its last state while the response register is full and rsp.ready is low.
// Async active-low reset clears control state.
`include "assert_macros.svh"

module ternary_search_sorted_table import ts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ts_req_if.sink            req,
  ts_rsp_if.source          rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          entries_q;
  logic signed [BOUND_W-1:0] low_q, low_d;
  logic signed [BOUND_W-1:0] high_q, high_d;
  logic [IDX_W-1:0]          m1_q, m1_d;
  logic [IDX_W-1:0]          m2_q, m2_d;
  logic signed [VALUE_W-1:0] key_q;
  logic                      rsp_valid_q;
  logic                      found_q, found_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic                      res_found_q, res_found_d;
  logic [IDX_W-1:0]          res_pos_q, res_pos_d;
  logic                      load_rsp;

  logic                      in_fire;
  logic                      ram_we;
  logic [VALUE_W-1:0]        rdata_a, rdata_b;
  logic signed [VALUE_W-1:0] v1, v2;
  logic [CNT_W-1:0]          n_sat;
  logic signed [BOUND_W-1:0] span;
  logic [IDX_W-1:0]          third;
  logic signed [BOUND_W-1:0] m1_full, m2_full;
  logic                      cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (reg_e'(paddr[APB_AW-1]) == REG_ENTRIES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_wr) begin
      entries_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_e'(paddr[APB_AW-1]) == REG_ENTRIES_IN_USE) begin
      prdata = {{(APB_DW-CNT_W){1'b0}}, entries_q};
    end
  end

  // Table storage
  assign in_fire = req.valid && req.ready;
  assign ram_we  = in_fire && (cmd_e'(req.command) == CMD_WRITE);

  ts_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (req.entry_index),
    .wdata_i   (req.entry_value),
    .raddr_a_i (m1_d),
    .raddr_b_i (m2_d),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign v1 = $signed(rdata_a);
  assign v2 = $signed(rdata_b);

  // Probe points
  assign n_sat   = (entries_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_q;
  assign span    = high_q - low_q;
  assign third   = div3(span[IDX_W-1:0]);
  assign m1_full = low_q + $signed({2'b00, third});
  assign m2_full = high_q - $signed({2'b00, third});

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q       <= low_d;
    high_q      <= high_d;
    m1_q        <= m1_d;
    m2_q        <= m2_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    if (in_fire) begin
      key_q <= req.search_key;
    end
  end

  assign req.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    high_d      = high_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    load_rsp    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (cmd_e'(req.command) == CMD_SEARCH)) begin
          low_d       = '0;
          high_d      = $signed({1'b0, n_sat}) - BOUND_W'(1);
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (high_q < low_q) begin
          state_d = S_DONE;
        end else begin
          m1_d    = m1_full[IDX_W-1:0];
          m2_d    = m2_full[IDX_W-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_CHECK;
        if (v1 == key_q) begin
          res_found_d = 1'b1;
          res_pos_d   = m1_q;
          state_d     = S_DONE;
        end else if (v2 == key_q) begin
          res_found_d = 1'b1;
          res_pos_d   = m2_q;
          state_d     = S_DONE;
        end else if (key_q < v1) begin
          high_d = $signed({2'b00, m1_q}) - BOUND_W'(1);
        end else if (key_q > v2) begin
          low_d = $signed({2'b00, m2_q}) + BOUND_W'(1);
        end else begin
          low_d  = $signed({2'b00, m1_q}) + BOUND_W'(1);
          high_d = $signed({2'b00, m2_q}) - BOUND_W'(1);
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          load_rsp = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response register
  assign found_d = load_rsp ? res_found_q : found_q;
  assign pos_d   = load_rsp ? res_pos_q : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  assign rsp.valid    = rsp_valid_q;
  assign rsp.found    = found_q;
  assign rsp.position = pos_q;

  `TS_ASSERT_IMP(a_probe_order, clk_i, rst_ni, state_q == S_CMP, m1_q <= m2_q)
  `TS_ASSERT_IMP(a_miss_pos_zero, clk_i, rst_ni, rsp_valid_q && !found_q, pos_q == '0)
  `TS_ASSERT_NEXT(a_cmp_next, clk_i, rst_ni, state_q == S_CMP,
                  state_q == S_CHECK || state_q == S_DONE)
  `TS_ASSERT_NEXT(a_search_starts, clk_i, rst_ni,
                  in_fire && (cmd_e'(req.command) == CMD_SEARCH), state_q == S_CHECK)

endmodule

// ===== sv/ts_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module ts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
